// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sgr_pkg.sv
// ---------------------------------------------------------------------------
// SGR parser package
// Byte codes, SGR codes, controller types and the attribute update function.
// ---------------------------------------------------------------------------
package sgr_pkg;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam logic [7:0] SGR_RESET     = 8'd0;
  localparam logic [7:0] SGR_BOLD      = 8'd1;
  localparam logic [7:0] SGR_NORMAL    = 8'd22;
  localparam logic [7:0] SGR_FG_DEF    = 8'd39;
  localparam logic [7:0] SGR_BG_DEF    = 8'd49;
  localparam logic [7:0] SGR_FG_BASE   = 8'd30;
  localparam logic [7:0] SGR_FG_BRIGHT = 8'd90;
  localparam logic [7:0] SGR_BG_BASE   = 8'd40;
  localparam logic [7:0] SGR_BG_BRIGHT = 8'd100;
  localparam logic [7:0] SGR_SPAN      = 8'd7;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  // Register index of default_attr; the register sits at byte address 4 * index.
  localparam logic REG_DEFAULT_ATTR = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ESC,
    S_CSI,
    S_APPLY,
    S_SECOND
  } sgr_state_t;

  typedef enum logic [1:0] {
    OSEL_BYTE,
    OSEL_ESC,
    OSEL_PEND
  } sgr_osel_t;

  typedef struct packed {
    logic      out_load;
    sgr_osel_t osel;
    logic      out_last;
    logic      pend_load;
    logic      csi_start;
    logic      digit;
    logic      semi;
    logic      term;
    logic      term_m;
    logic      apply_step;
  } sgr_cmd_t;

  typedef struct packed {
    logic is_esc;
    logic is_lbr;
    logic is_digit;
    logic is_semi;
    logic is_m;
    logic byte_last;
    logic out_free;
    logic codes_present;
    logic apply_last;
  } sgr_sts_t;

  // ANSI color order to VGA index: bits 0 and 2 swap, bit 3 is brightness.
  function automatic logic [3:0] vga_color(input logic [2:0] idx, input logic bright);
    return {bright, idx[0], idx[1], idx[2]};
  endfunction

  function automatic logic [7:0] sgr_apply(input logic [7:0] cur, input logic [7:0] code,
                                           input logic [7:0] dflt);
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] ofs;
    logic [7:0] res;
    fg  = cur[3:0];
    bg  = cur[7:4];
    ofs = 8'd0;
    res = cur;
    if (code == SGR_RESET) begin
      res = dflt;
    end else if (code == SGR_BOLD) begin
      fg[3] = 1'b1;
      res = {bg, fg};
    end else if (code == SGR_NORMAL) begin
      fg[3] = 1'b0;
      res = {bg, fg};
    end else if (code == SGR_FG_DEF) begin
      res = {bg, dflt[3:0]};
    end else if (code == SGR_BG_DEF) begin
      res = {dflt[7:4], fg};
    end else if (code >= SGR_FG_BASE && code <= SGR_FG_BASE + SGR_SPAN) begin
      ofs = code - SGR_FG_BASE;
      res = {bg, vga_color(ofs[2:0], 1'b0)};
    end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT + SGR_SPAN) begin
      ofs = code - SGR_FG_BRIGHT;
      res = {bg, vga_color(ofs[2:0], 1'b1)};
    end else if (code >= SGR_BG_BASE && code <= SGR_BG_BASE + SGR_SPAN) begin
      ofs = code - SGR_BG_BASE;
      res = {vga_color(ofs[2:0], 1'b0), fg};
    end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT + SGR_SPAN) begin
      ofs = code - SGR_BG_BRIGHT;
      res = {vga_color(ofs[2:0], 1'b1), fg};
    end
    return res;
  endfunction

endpackage

// File: hdl/sgr_dp.sv
// ---------------------------------------------------------------------------
// SGR parser datapath
// Number accumulator, code buffer, attribute register and output word register.
// ---------------------------------------------------------------------------
module sgr_dp
  import sgr_pkg::*;
#(
  parameter int MAX_CODES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last_of_write,
  input  logic [7:0] default_attr,
  input  sgr_cmd_t   cmd,
  output sgr_sts_t   sts,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic [7:0] out_attr,
  output logic       out_last
);

  localparam int TOT_W = $clog2(MAX_CODES + 1);
  localparam int IDX_W = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

  logic [7:0]       accum_r;
  logic [7:0]       accum_nxt;
  logic             have_r;
  logic [TOT_W-1:0] total_r;
  logic [IDX_W-1:0] k_r;
  logic [7:0]       attr_r;
  logic [7:0]       code_r [MAX_CODES];
  logic [7:0]       pend_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic [7:0]       out_attr_r;
  logic             out_last_r;
  logic [11:0]      dec_sum;
  logic             can_push;
  logic [7:0]       semi_code;
  logic [7:0]       load_char;

  // accum * 10 + digit, saturating at 255.
  assign dec_sum   = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0}
                   + {8'd0, in_byte[3:0]};
  assign accum_nxt = (dec_sum > 12'd255) ? 8'hFF : dec_sum[7:0];
  assign can_push  = (total_r != TOT_W'(MAX_CODES));
  assign semi_code = have_r ? accum_r : 8'd0;

  always_comb begin
    case (cmd.osel)
      OSEL_ESC:  load_char = CH_ESC;
      OSEL_PEND: load_char = pend_r;
      default:   load_char = in_byte;
    endcase
  end

  assign sts.is_esc        = (in_byte == CH_ESC);
  assign sts.is_lbr        = (in_byte == CH_LBR);
  assign sts.is_digit      = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign sts.is_semi       = (in_byte == CH_SEMI);
  assign sts.is_m          = (in_byte == CH_M);
  assign sts.byte_last     = in_last_of_write;
  assign sts.out_free      = !out_valid_r || out_ready;
  assign sts.codes_present = (total_r != '0) || have_r;
  assign sts.apply_last    = ((TOT_W'(k_r) + TOT_W'(1)) == total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= 8'd0;
      have_r      <= 1'b0;
      total_r     <= '0;
      k_r         <= '0;
      attr_r      <= ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.csi_start) begin
        accum_r <= 8'd0;
        have_r  <= 1'b0;
        total_r <= '0;
      end else if (cmd.digit) begin
        accum_r <= accum_nxt;
        have_r  <= 1'b1;
      end else if (cmd.semi) begin
        accum_r <= 8'd0;
        have_r  <= 1'b0;
        if (can_push) begin
          total_r <= total_r + TOT_W'(1);
        end
      end else if (cmd.term) begin
        k_r <= '0;
        if (have_r && can_push) begin
          total_r <= total_r + TOT_W'(1);
        end
        if (cmd.term_m && !sts.codes_present) begin
          attr_r <= default_attr;
        end
      end else if (cmd.apply_step) begin
        attr_r <= sgr_apply(attr_r, code_r[k_r], default_attr);
        k_r    <= k_r + IDX_W'(1);
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Code buffer and output payload carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.semi && can_push) begin
      code_r[total_r[IDX_W-1:0]] <= semi_code;
    end else if (cmd.term && have_r && can_push) begin
      code_r[total_r[IDX_W-1:0]] <= accum_r;
    end
    if (cmd.pend_load) begin
      pend_r <= in_byte;
    end
    if (cmd.out_load) begin
      out_char_r <= load_char;
      out_attr_r <= attr_r;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_attr  = out_attr_r;
  assign out_last  = out_last_r;

endmodule

// File: hdl/sgr_ctrl.sv
// ---------------------------------------------------------------------------
// SGR parser controller
// Parse mode sequencing, code apply loop and second word of an ESC pair.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sgr_ctrl
  import sgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sgr_sts_t sts,
  output sgr_cmd_t cmd
);

  sgr_state_t state_r;
  sgr_state_t state_nxt;
  logic       accepting;
  logic       acc;

  assign accepting = (state_r == S_IDLE) || (state_r == S_ESC) || (state_r == S_CSI);
  assign in_ready  = accepting && sts.out_free;
  assign acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && sts.is_esc && !sts.byte_last) begin
          state_nxt = S_ESC;
        end
      end
      S_ESC: begin
        if (acc) begin
          if (sts.is_lbr) begin
            state_nxt = sts.byte_last ? S_IDLE : S_CSI;
          end else if (!(sts.is_esc && !sts.byte_last)) begin
            state_nxt = S_SECOND;
          end
        end
      end
      S_CSI: begin
        if (acc) begin
          if (sts.is_digit || sts.is_semi) begin
            if (sts.byte_last) begin
              state_nxt = S_IDLE;
            end
          end else if (sts.is_m && sts.codes_present) begin
            state_nxt = S_APPLY;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_APPLY: begin
        if (sts.apply_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_SECOND: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.osel = OSEL_BYTE;
    unique case (state_r)
      S_IDLE: begin
        if (acc && !(sts.is_esc && !sts.byte_last)) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
        end
      end
      S_ESC: begin
        if (acc) begin
          if (sts.is_lbr) begin
            cmd.csi_start = !sts.byte_last;
          end else if (sts.is_esc && !sts.byte_last) begin
            cmd.out_load = 1'b1;
            cmd.osel     = OSEL_ESC;
            cmd.out_last = 1'b1;
          end else begin
            cmd.out_load  = 1'b1;
            cmd.osel      = OSEL_ESC;
            cmd.pend_load = 1'b1;
          end
        end
      end
      S_CSI: begin
        if (acc) begin
          if (sts.is_digit) begin
            cmd.digit = 1'b1;
          end else if (sts.is_semi) begin
            cmd.semi = 1'b1;
          end else begin
            cmd.term   = 1'b1;
            cmd.term_m = sts.is_m;
          end
        end
      end
      S_APPLY: begin
        cmd.apply_step = 1'b1;
      end
      S_SECOND: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.osel     = OSEL_PEND;
          cmd.out_last = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  // A word is only loaded into a free output register.
  `ASSERT_SAME(a_load_free, cmd.out_load, sts.out_free, "output word overwritten")
  // The apply loop runs without a break until its final code.
  `ASSERT_NEXT(a_apply_runs, (state_r == S_APPLY) && !sts.apply_last, state_r == S_APPLY, "apply loop ended early")
  // The second word of a pair is only owed after an escape.
  `ASSERT_SAME(a_second_src, state_r == S_SECOND, ($past(state_r) == S_ESC) || ($past(state_r) == S_SECOND), "stray second word")

endmodule

// File: hdl/ansi_sgr_color_parser_core.sv
// ---------------------------------------------------------------------------
// ANSI SGR color parser core
// Output: a word loaded when its byte is accepted stands in the output register the cycle after.
// Throughput: one byte per cycle while the output register is free. ESC then a byte other than '['
// or another ESC not closing the write yields two words; the input waits while the second is loaded
// as soon as the output register frees. An 'm' with buffered codes holds the input while they are walked.
// Reset (rst_n, synchronous): parser idle, attribute 0x07, default_attr 0x07; no clearing pass.
// ---------------------------------------------------------------------------
module ansi_sgr_color_parser_core
  import sgr_pkg::*;
#(
  parameter int MAX_CODES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_of_write,
  // Result word channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic [7:0]  out_attr,
  output logic        out_last,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] default_attr_r;
  logic       cfg_wr;
  sgr_cmd_t   cmd;
  sgr_sts_t   sts;

  // The port never inserts wait states, so a write lands at the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= ATTR_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_DEFAULT_ATTR)) begin
      default_attr_r <= cfg_pwdata[7:0];
    end
  end

  // Reads return the one register wherever address bit 2 is clear, and zero otherwise.
  assign cfg_prdata = (cfg_paddr[2] == REG_DEFAULT_ATTR) ? {24'd0, default_attr_r} : 32'd0;

  // The controller tracks the parse mode and sequences the apply loop; the
  // datapath holds the number accumulator, the code buffer, the current
  // attribute and the output word register.
  sgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgr_dp #(
    .MAX_CODES (MAX_CODES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_byte),
    .in_last_of_write (in_last_of_write),
    .default_attr     (default_attr_r),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char         (out_char),
    .out_attr         (out_attr),
    .out_last         (out_last)
  );

endmodule

// File: sim/ansi_sgr_color_parser_core_tb.sv
// ----------------------------------------------------------------------------
// ANSI SGR color parser core testbench
// Streams terminal bytes through the parser and compares each printed word
// against a cycle-free parser model kept in the bench. A short directed table
// comes first, then random bursts of escape sequences, plain text and broken
// sequences under several default attribute settings, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ansi_sgr_color_parser_core_tb;
  import sgr_pkg::*;

  localparam int CODE_SLOTS = 8;
  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  // Settle time once the last word is out: an 'm' may still be applying codes.
  localparam int SETTLE_CYCLES = 20;
  localparam int BYTES_PER_PHASE = 170;
  localparam int PHASES = 6;

  // One printed word: character, attribute in force, last-of-byte flag.
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
    logic       last;
  } screen_cell_t;

  // One row of the directed table. Rows with has_cell set carry the word
  // that is typed in by hand; all other rows are checked by the model.
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       has_cell;
    logic [7:0] cell_ch;
    logic [7:0] cell_attr;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last_of_write;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic [7:0]  out_attr;
  logic        out_last;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ansi_sgr_color_parser_core #(
    .MAX_CODES(CODE_SLOTS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last_of_write(in_last_of_write),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_attr        (out_attr),
    .out_last        (out_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  // Words the parser still owes us, oldest first.
  screen_cell_t screen_cells_q[$];
  stim_row_t    table_rows[$];
  logic [7:0]   burst_bytes[$];
  logic         burst_lasts[$];

  int error_count;
  int bytes_sent;
  int hang_count;
  // When clear, the matching side never idles.
  logic in_gaps_on;
  logic out_gaps_on;

  // Parser model state. It mirrors what the block holds, not how it holds it.
  sgr_state_t  pm_mode;
  logic [7:0]  pm_attr;
  logic [7:0]  pm_default;
  logic [7:0]  pm_number;
  logic        pm_has_digits;
  logic [7:0]  pm_codes [CODE_SLOTS];
  int          pm_code_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // ANSI color order is black, red, green, yellow, blue, magenta, cyan, white;
  // the VGA palette swaps red with blue and yellow with cyan. Bright adds 8.
  function automatic logic [3:0] ansi_to_vga(input logic [7:0] idx, input logic bright);
    logic [3:0] v;
    case (idx)
      8'd0: v = 4'd0;
      8'd1: v = 4'd4;
      8'd2: v = 4'd2;
      8'd3: v = 4'd6;
      8'd4: v = 4'd1;
      8'd5: v = 4'd5;
      8'd6: v = 4'd3;
      default: v = 4'd7;
    endcase
    return bright ? v + 4'd8 : v;
  endfunction

  // Attribute after one SGR code. Unknown codes leave the attribute as is.
  function automatic logic [7:0] next_attr(input logic [7:0] cur, input logic [7:0] code,
                                           input logic [7:0] dflt);
    logic [3:0] fg;
    logic [3:0] bg;
    fg = cur[3:0];
    bg = cur[7:4];
    if (code == SGR_RESET) begin
      return dflt;
    end
    if (code == SGR_BOLD) begin
      if (fg < 4'd8) fg = fg + 4'd8;
    end else if (code == SGR_NORMAL) begin
      if (fg >= 4'd8) fg = fg - 4'd8;
    end else if (code == SGR_FG_DEF) begin
      fg = dflt[3:0];
    end else if (code == SGR_BG_DEF) begin
      bg = dflt[7:4];
    end else if (code >= SGR_FG_BASE && code <= SGR_FG_BASE + SGR_SPAN) begin
      fg = ansi_to_vga(code - SGR_FG_BASE, 1'b0);
    end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT + SGR_SPAN) begin
      fg = ansi_to_vga(code - SGR_FG_BRIGHT, 1'b1);
    end else if (code >= SGR_BG_BASE && code <= SGR_BG_BASE + SGR_SPAN) begin
      bg = ansi_to_vga(code - SGR_BG_BASE, 1'b0);
    end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT + SGR_SPAN) begin
      bg = ansi_to_vga(code - SGR_BG_BRIGHT, 1'b1);
    end
    return {bg, fg};
  endfunction

  task automatic store_code(input logic [7:0] v);
    if (pm_code_count < CODE_SLOTS) begin
      pm_codes[pm_code_count] = v;
      pm_code_count++;
    end
  endtask

  // Advances the parser model by one accepted byte and returns the words it
  // prints (zero, one or two). The last one printed carries the last flag.
  task automatic parse_byte(input logic [7:0] b, input logic l, output int n,
                            output screen_cell_t w0, output screen_cell_t w1);
    int v;
    n = 0;
    w0 = '0;
    w1 = '0;
    case (pm_mode)
      S_ESC: begin
        if (b == CH_LBR) begin
          // ESC '[' that closes the write is dropped without a trace.
          if (l) begin
            pm_mode = S_IDLE;
          end else begin
            pm_number = 8'd0;
            pm_has_digits = 1'b0;
            pm_code_count = 0;
            pm_mode = S_CSI;
          end
        end else if (b == CH_ESC && !l) begin
          // The pending ESC is printed; the new one waits for its '['.
          w0 = '{ch: CH_ESC, attr: pm_attr, last: 1'b0};
          n = 1;
        end else begin
          w0 = '{ch: CH_ESC, attr: pm_attr, last: 1'b0};
          w1 = '{ch: b, attr: pm_attr, last: 1'b0};
          n = 2;
          pm_mode = S_IDLE;
        end
      end
      S_CSI: begin
        if (b >= CH_0 && b <= CH_9) begin
          v = pm_number * 10 + (b - CH_0);
          pm_number = (v > 255) ? 8'd255 : v[7:0];
          pm_has_digits = 1'b1;
          if (l) pm_mode = S_IDLE;
        end else if (b == CH_SEMI) begin
          // An empty field counts as code zero.
          store_code(pm_has_digits ? pm_number : 8'd0);
          pm_number = 8'd0;
          pm_has_digits = 1'b0;
          if (l) pm_mode = S_IDLE;
        end else begin
          // Any other byte ends the sequence; only 'm' applies the codes.
          if (pm_has_digits) store_code(pm_number);
          if (b == CH_M) begin
            if (pm_code_count == 0) pm_attr = pm_default;
            for (int k = 0; k < pm_code_count; k++) begin
              pm_attr = next_attr(pm_attr, pm_codes[k], pm_default);
            end
          end
          pm_mode = S_IDLE;
        end
      end
      default: begin
        pm_mode = S_IDLE;
        if (b == CH_ESC && !l) begin
          pm_mode = S_ESC;
        end else begin
          w0 = '{ch: b, attr: pm_attr, last: 1'b0};
          n = 1;
        end
      end
    endcase
    if (n == 1) w0.last = 1'b1;
    if (n == 2) w1.last = 1'b1;
  endtask

  // Offers one byte and waits for it to be taken. Entered and left just after
  // a falling edge, so in_valid gets exactly one update per edge.
  task automatic send_byte(input logic [7:0] b, input logic l, input logic has_cell,
                           input logic [7:0] cell_ch, input logic [7:0] cell_attr);
    int n;
    screen_cell_t w0;
    screen_cell_t w1;
    while (in_gaps_on && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last_of_write <= l;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, l, n, w0, w1);
    if (has_cell) begin
      screen_cells_q.push_back('{ch: cell_ch, attr: cell_attr, last: 1'b1});
    end else begin
      if (n > 0) screen_cells_q.push_back(w0);
      if (n > 1) screen_cells_q.push_back(w1);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // Waits until every word has come out and any code walk has finished.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (screen_cells_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes default_attr over the register port, then reads it back.
  task automatic write_default_attr(input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {REG_DEFAULT_ATTR, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    pm_default = value;
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'd0, value}) begin
      report_mismatch($sformatf("default_attr read %h, wrote %h", cfg_prdata, value));
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] b, input logic l, input logic has_cell,
                         input logic [7:0] cell_ch, input logic [7:0] cell_attr);
    table_rows.push_back('{b: b, l: l, has_cell: has_cell, cell_ch: cell_ch,
                           cell_attr: cell_attr});
  endtask

  // Adds a string as model-checked rows, none of them closing the write.
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, 8'd0, 8'd0);
  endtask

  task automatic add_burst_byte(input logic [7:0] b, input logic l);
    burst_bytes.push_back(b);
    burst_lasts.push_back(l);
  endtask

  // Decimal text of one SGR field. Most fields are codes the parser knows;
  // the rest are empty, arbitrary, zero-padded or too large for 8 bits.
  task automatic add_code_field();
    string s;
    int    pick;
    int    v;
    pick = $urandom_range(0, 9);
    case (pick)
      0: s = "";
      1: begin
        case ($urandom_range(0, 4))
          0: v = SGR_RESET;
          1: v = SGR_BOLD;
          2: v = SGR_NORMAL;
          3: v = SGR_FG_DEF;
          default: v = SGR_BG_DEF;
        endcase
        s = $sformatf("%0d", v);
      end
      4: s = $sformatf("%0d", $urandom_range(0, 255));
      5: s = $sformatf("%0d", $urandom_range(256, 99999));
      6: s = $sformatf("00%0d", $urandom_range(0, 49));
      default: begin
        case ($urandom_range(0, 3))
          0: v = SGR_FG_BASE;
          1: v = SGR_FG_BRIGHT;
          2: v = SGR_BG_BASE;
          default: v = SGR_BG_BRIGHT;
        endcase
        s = $sformatf("%0d", v + $urandom_range(0, 8));
      end
    endcase
    for (int i = 0; i < s.len(); i++) add_burst_byte(s[i], 1'b0);
  endtask

  // Fills the burst queues with one random unit: an SGR sequence (most of
  // the time), a run of raw bytes, or a broken escape.
  task automatic build_burst();
    int         kind;
    int         fields;
    int         cut;
    logic [7:0] t;
    burst_bytes.delete();
    burst_lasts.delete();
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      add_burst_byte(CH_ESC, 1'b0);
      add_burst_byte(CH_LBR, 1'b0);
      fields = $urandom_range(0, 99);
      fields = (fields < 10) ? 0 : (fields < 88) ? $urandom_range(1, 4) : $urandom_range(5, 11);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) add_burst_byte(CH_SEMI, 1'b0);
        add_code_field();
      end
      if ($urandom_range(0, 9) == 0) add_burst_byte(CH_SEMI, 1'b0);
      if ($urandom_range(0, 99) < 85) begin
        t = CH_M;
      end else begin
        // Some other final byte: anything but a digit or a separator.
        do t = 8'($urandom_range(0, 255)); while ((t >= CH_0 && t <= CH_9) || t == CH_SEMI);
      end
      add_burst_byte(t, $urandom_range(0, 99) < 20);
      // Now and then the write ends inside the sequence.
      if ($urandom_range(0, 99) < 8) begin
        cut = $urandom_range(1, burst_bytes.size() - 1);
        while (burst_bytes.size() > cut + 1) begin
          void'(burst_bytes.pop_back());
          void'(burst_lasts.pop_back());
        end
        burst_lasts[cut] = 1'b1;
      end
    end else if (kind < 85) begin
      fields = $urandom_range(1, 8);
      for (int i = 0; i < fields; i++) begin
        add_burst_byte(8'($urandom_range(0, 255)),
                       (i == fields - 1) && $urandom_range(0, 99) < 40);
      end
    end else begin
      add_burst_byte(CH_ESC, 1'b0);
      case ($urandom_range(0, 4))
        0: add_burst_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1: begin
          add_burst_byte(CH_ESC, 1'b0);
          add_burst_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        2: burst_lasts[0] = 1'b1;
        3: add_burst_byte(CH_LBR, 1'b1);
        default: add_burst_byte(8'($urandom_range(0, 255)), 1'b1);
      endcase
    end
  endtask

  // Result side: random back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready <= !out_gaps_on || ($urandom_range(0, 99) >= 30);
  end

  // Each word taken from the parser is compared with the oldest word owed.
  always @(posedge clk) begin : check_words
    screen_cell_t want;
    if (rst_n && out_valid && out_ready) begin
      if (screen_cells_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word char %h attr %h last %b",
                                  out_char, out_attr, out_last));
      end else begin
        want = screen_cells_q.pop_front();
        if (out_char !== want.ch) begin
          report_mismatch($sformatf("out_char %h, want %h", out_char, want.ch));
        end
        if (out_attr !== want.attr) begin
          report_mismatch($sformatf("out_attr %h, want %h (char %h)", out_attr, want.attr,
                                    want.ch));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("out_last %b, want %b (char %h)", out_last, want.last,
                                    want.ch));
        end
      end
    end
  end

  // Hang guard: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words still owed", HANG_LIMIT,
               screen_cells_q.size());
      $display("ansi_sgr_color_parser_core_tb: FAIL");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  initial begin
    // Every input starts at a known value while reset is held.
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'd0;
    in_last_of_write = 1'b0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    error_count = 0;
    bytes_sent = 0;
    hang_count = 0;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;

    pm_mode = S_IDLE;
    pm_attr = ATTR_RESET;
    pm_default = ATTR_RESET;
    pm_number = 8'd0;
    pm_has_digits = 1'b0;
    pm_code_count = 0;
    for (int i = 0; i < CODE_SLOTS; i++) pm_codes[i] = 8'd0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table. The first rows print under the reset attribute.
    add_row("A", 1'b0, 1'b1, "A", ATTR_RESET);
    add_row(8'h00, 1'b0, 1'b1, 8'h00, ATTR_RESET);
    add_row(8'hFF, 1'b1, 1'b1, 8'hFF, ATTR_RESET);
    // Oversized number saturates, six empty fields reset, bold is the eighth
    // code and the ninth (31) is dropped, so 'x' comes out bright grey.
    add_row(CH_ESC, 1'b0, 1'b0, 8'd0, 8'd0);
    add_text("[999;;;;;;;1;31m");
    add_text("x");
    // ESC ESC prints the first ESC; the empty list then restores the default.
    add_row(CH_ESC, 1'b0, 1'b0, 8'd0, 8'd0);
    add_row(CH_ESC, 1'b0, 1'b0, 8'd0, 8'd0);
    add_text("[m");
    // ESC '[' closing the write prints nothing.
    add_row(CH_ESC, 1'b0, 1'b0, 8'd0, 8'd0);
    add_row(CH_LBR, 1'b1, 1'b0, 8'd0, 8'd0);
    foreach (table_rows[i]) begin
      send_byte(table_rows[i].b, table_rows[i].l, table_rows[i].has_cell,
                table_rows[i].cell_ch, table_rows[i].cell_attr);
    end
    drain_outputs();

    // Random phases, each under its own default attribute. Draining between
    // phases also makes the sender wait until every word has arrived.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_default_attr(8'h00);
        1: write_default_attr(8'hFF);
        4: write_default_attr(8'h17);
        default: write_default_attr(8'($urandom_range(0, 255)));
      endcase
      @(negedge clk);
      // One phase runs with both sides streaming back to back.
      in_gaps_on = (ph != 2);
      out_gaps_on = (ph != 2);
      bytes_sent = 0;
      while (bytes_sent < BYTES_PER_PHASE) begin
        build_burst();
        foreach (burst_bytes[i]) send_byte(burst_bytes[i], burst_lasts[i], 1'b0, 8'd0, 8'd0);
      end
      drain_outputs();
    end

    if (error_count == 0) begin
      $display("ansi_sgr_color_parser_core_tb: PASS");
    end else begin
      $display("ansi_sgr_color_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule
